### src/qrtm_pkg.sv
// qrtm_pkg: shared types and constants for the quad rotor thrust mixer
// no dependencies; used by every module in src
package qrtm_pkg;

   localparam int LANES      = 4;
   localparam int DEMAND_W   = 24;
   localparam int GAIN_W     = 24;
   localparam int IMC_W      = 30;
   localparam int SQRT_BITS  = 19;
   localparam int SPEED_W    = SQRT_BITS + 1;
   localparam int MASS_W     = 16;
   localparam int BASE_W     = DEMAND_W + 14;
   localparam int PROD_W     = DEMAND_W + GAIN_W + 1;
   localparam int FRC_W      = PROD_W + 1;
   localparam int MAG_W      = FRC_W - 1 - 16;
   localparam int MAG_LO_W   = 17;
   localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
   localparam int SQ_PROD_W  = MAG_W + IMC_W;
   localparam int SQ_IN_W    = SQ_PROD_W - 8;
   localparam int ROOT_IN_W  = 2 * SQRT_BITS;
   localparam int REM_W      = SQRT_BITS + 2;
   localparam int MPROD_W    = DEMAND_W + GAIN_W;
   localparam int MMAG_W     = MPROD_W - 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   localparam int MIX_DEPTH  = 3;
   localparam int LANE_DEPTH = SQRT_BITS + 3;
   localparam int PIPE_DEPTH = MIX_DEPTH + LANE_DEPTH;
   localparam int MASS_CHAIN = PIPE_DEPTH - 1;

   localparam logic [MASS_W-2:0] MASS_SAT = 15'd32767;

   localparam logic [CSR_IDX_W-1:0] CSR_MASS_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RP_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MOTOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS_GAIN  = 3'd5;

   localparam logic [GAIN_W-1:0]    RST_RP_GAIN    = 24'd83977;
   localparam logic [GAIN_W-1:0]    RST_YAW_GAIN   = 24'd1024000;
   localparam logic [IMC_W-1:0]     RST_INV_MOTOR  = 30'd29946448;
   localparam logic [SQRT_BITS-1:0] RST_MAX_SPEED  = 19'd377600;
   localparam logic [GAIN_W-1:0]    RST_MASS_GAIN  = 24'd102290;

   typedef struct packed {
      logic signed [DEMAND_W-1:0] total_thrust;
      logic signed [DEMAND_W-1:0] roll_moment;
      logic signed [DEMAND_W-1:0] pitch_moment;
      logic signed [DEMAND_W-1:0] yaw_moment;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_front;
      logic signed [SPEED_W-1:0] speed_right;
      logic signed [SPEED_W-1:0] speed_back;
      logic signed [SPEED_W-1:0] speed_left;
      logic signed [MASS_W-1:0]  mass_front;
      logic signed [MASS_W-1:0]  mass_right;
      logic signed [MASS_W-1:0]  mass_back;
      logic signed [MASS_W-1:0]  mass_left;
   } rsp_type;

   typedef struct packed {
      logic                 mass_mode;
      logic [GAIN_W-1:0]    rp_gain;
      logic [GAIN_W-1:0]    yaw_gain;
      logic [IMC_W-1:0]     inv_motor;
      logic [SQRT_BITS-1:0] max_speed;
      logic [GAIN_W-1:0]    mass_gain;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } lane_in_type;

   typedef struct packed {
      logic                      valid;
      logic signed [SPEED_W-1:0] speed;
   } lane_out_type;

   typedef struct packed {
      logic                     valid;
      logic signed [MASS_W-1:0] front;
      logic signed [MASS_W-1:0] right;
      logic signed [MASS_W-1:0] back;
      logic signed [MASS_W-1:0] left;
   } mass_out_type;

endpackage

### src/qrtm_mix.sv
// qrtm_mix: moment products, rotor force sums and force magnitudes, three stages
// depends on qrtm_pkg
module qrtm_mix (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  qrtm_pkg::req_type                      req,
   input  qrtm_pkg::cfg_type                      cfg,
   output qrtm_pkg::lane_in_type [qrtm_pkg::LANES-1:0] lane_out
);

   logic                                  valid1_ff;
   logic signed [qrtm_pkg::BASE_W-1:0]    base_ff, base_in;
   logic signed [qrtm_pkg::PROD_W-1:0]    pt_ff, pt_in;
   logic signed [qrtm_pkg::PROD_W-1:0]    rt_ff, rt_in;
   logic signed [qrtm_pkg::PROD_W-1:0]    yt_ff, yt_in;

   logic                                  valid2_ff;
   logic signed [qrtm_pkg::FRC_W-1:0]     frc_ff [qrtm_pkg::LANES];
   logic signed [qrtm_pkg::FRC_W-1:0]     frc_in [qrtm_pkg::LANES];
   logic signed [qrtm_pkg::FRC_W-1:0]     b_ext, p_ext, r_ext, y_ext;

   qrtm_pkg::lane_in_type [qrtm_pkg::LANES-1:0] lane_ff, lane_in;

   // stage 1: moment products
   always_comb begin
      base_in = {req.total_thrust, 14'b0};
      yt_in   = $signed(req.yaw_moment) * $signed({1'b0, cfg.yaw_gain});
      if (cfg.mass_mode) begin
         pt_in = '0;
         rt_in = '0;
      end else begin
         pt_in = $signed(req.pitch_moment) * $signed({1'b0, cfg.rp_gain});
         rt_in = $signed(req.roll_moment) * $signed({1'b0, cfg.rp_gain});
      end
   end

   // stage 2: rotor forces
   always_comb begin
      b_ext = qrtm_pkg::FRC_W'(base_ff);
      p_ext = qrtm_pkg::FRC_W'(pt_ff);
      r_ext = qrtm_pkg::FRC_W'(rt_ff);
      y_ext = qrtm_pkg::FRC_W'(yt_ff);
      frc_in[0] = b_ext - p_ext + y_ext;
      frc_in[1] = b_ext + r_ext - y_ext;
      frc_in[2] = b_ext + p_ext + y_ext;
      frc_in[3] = b_ext - r_ext - y_ext;
   end

   // stage 3: sign and truncated magnitude
   always_comb begin
      for (int i = 0; i < qrtm_pkg::LANES; i++) begin
         logic signed [qrtm_pkg::FRC_W-1:0] absv;
         absv = frc_ff[i][qrtm_pkg::FRC_W-1] ? -frc_ff[i] : frc_ff[i];
         lane_in[i].valid = valid2_ff;
         lane_in[i].neg   = frc_ff[i][qrtm_pkg::FRC_W-1];
         lane_in[i].mag   = absv[qrtm_pkg::FRC_W-2:16];
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      pt_ff   <= pt_in;
      rt_ff   <= rt_in;
      yt_ff   <= yt_in;
      for (int i = 0; i < qrtm_pkg::LANES; i++) begin
         frc_ff[i]      <= frc_in[i];
         lane_ff[i].neg <= lane_in[i].neg;
         lane_ff[i].mag <= lane_in[i].mag;
      end
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         for (int i = 0; i < qrtm_pkg::LANES; i++) begin
            lane_ff[i].valid <= 1'b0;
         end
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         for (int i = 0; i < qrtm_pkg::LANES; i++) begin
            lane_ff[i].valid <= lane_in[i].valid;
         end
      end
   end

   assign lane_out = lane_ff;

endmodule

### src/qrtm_lane.sv
// qrtm_lane: one rotor's speed path, split multiply then a bit-per-stage square root
// depends on qrtm_pkg
module qrtm_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  qrtm_pkg::lane_in_type  lane_in,
   input  qrtm_pkg::cfg_type      cfg,
   output qrtm_pkg::lane_out_type lane_out
);

   localparam int N = qrtm_pkg::SQRT_BITS;

   // stage a: partial products
   logic                                             va_ff;
   logic                                             nega_ff;
   logic [qrtm_pkg::MAG_LO_W+qrtm_pkg::IMC_W-1:0]    pl_ff, pl_in;
   logic [qrtm_pkg::MAG_HI_W+qrtm_pkg::IMC_W-1:0]    ph_ff, ph_in;

   // stage b: product sum
   logic [qrtm_pkg::SQ_PROD_W-1:0]                   prod;
   logic [qrtm_pkg::SQ_IN_W-1:0]                     xv;

   // root stages, index 0 is the stage b register
   logic                                  vr_ff    [N+1];
   logic                                  negr_ff  [N+1];
   logic                                  big_ff   [N+1];
   logic [qrtm_pkg::ROOT_IN_W-1:0]        xs_ff    [N+1];
   logic [qrtm_pkg::REM_W-1:0]            rem_ff   [N+1];
   logic [N-1:0]                          root_ff  [N+1];

   qrtm_pkg::lane_out_type                out_ff, out_in;
   logic [N-1:0]                          lim;

   assign pl_in = lane_in.mag[qrtm_pkg::MAG_LO_W-1:0] * cfg.inv_motor;
   assign ph_in = lane_in.mag[qrtm_pkg::MAG_W-1:qrtm_pkg::MAG_LO_W] * cfg.inv_motor;

   always_comb begin
      prod = qrtm_pkg::SQ_PROD_W'(pl_ff)
           + (qrtm_pkg::SQ_PROD_W'(ph_ff) << qrtm_pkg::MAG_LO_W);
      xv   = prod[qrtm_pkg::SQ_PROD_W-1:8];
   end

   always_ff @(posedge clock) begin
      nega_ff    <= lane_in.neg;
      pl_ff      <= pl_in;
      ph_ff      <= ph_in;
      negr_ff[0] <= nega_ff;
      big_ff[0]  <= |xv[qrtm_pkg::SQ_IN_W-1:qrtm_pkg::ROOT_IN_W];
      xs_ff[0]   <= xv[qrtm_pkg::ROOT_IN_W-1:0];
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar k = 0; k < N; k++) begin : g_root
      logic [qrtm_pkg::REM_W+1:0] acc;
      logic [qrtm_pkg::REM_W+1:0] trial;
      logic                       take;

      always_comb begin
         acc   = {rem_ff[k], xs_ff[k][qrtm_pkg::ROOT_IN_W-1:qrtm_pkg::ROOT_IN_W-2]};
         trial = (qrtm_pkg::REM_W+2)'({root_ff[k], 2'b01});
         take  = acc >= trial;
      end

      always_ff @(posedge clock) begin
         negr_ff[k+1] <= negr_ff[k];
         big_ff[k+1]  <= big_ff[k];
         xs_ff[k+1]   <= {xs_ff[k][qrtm_pkg::ROOT_IN_W-3:0], 2'b00};
         rem_ff[k+1]  <= take ? qrtm_pkg::REM_W'(acc - trial) : acc[qrtm_pkg::REM_W-1:0];
         root_ff[k+1] <= {root_ff[k][N-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vr_ff[k+1] <= 1'b0;
         end else begin
            vr_ff[k+1] <= vr_ff[k];
         end
      end
   end

   // limit and sign
   always_comb begin
      if (big_ff[N] || root_ff[N] > cfg.max_speed) begin
         lim = cfg.max_speed;
      end else begin
         lim = root_ff[N];
      end
      out_in.valid = vr_ff[N];
      out_in.speed = negr_ff[N] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
   end

   always_ff @(posedge clock) begin
      out_ff.speed <= out_in.speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vr_ff[0]     <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         va_ff        <= lane_in.valid;
         vr_ff[0]     <= va_ff;
         out_ff.valid <= out_in.valid;
      end
   end

   assign lane_out = out_ff;

endmodule

### src/qrtm_mass.sv
// qrtm_mass: moving-mass setpoints from roll and pitch, aligned to the speed lanes
// depends on qrtm_pkg
module qrtm_mass (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  qrtm_pkg::req_type      req,
   input  qrtm_pkg::cfg_type      cfg,
   output qrtm_pkg::mass_out_type mass_out
);

   localparam int C = qrtm_pkg::MASS_CHAIN;

   logic                              v1_ff;
   logic                              en_ff;
   logic                              negp_ff, negr_ff;
   logic [qrtm_pkg::DEMAND_W-1:0]     absp, absr;
   logic [qrtm_pkg::MPROD_W-1:0]      prodp_ff, prodp_in;
   logic [qrtm_pkg::MPROD_W-1:0]      prodr_ff, prodr_in;

   logic [qrtm_pkg::MMAG_W-1:0]       mp, mr;
   logic [qrtm_pkg::MASS_W-2:0]       sp, sr;
   logic signed [qrtm_pkg::MASS_W-1:0] posp, posr;
   qrtm_pkg::mass_out_type            sat_in;

   qrtm_pkg::mass_out_type            chain_ff [C];

   always_comb begin
      absp = req.pitch_moment[qrtm_pkg::DEMAND_W-1]
           ? qrtm_pkg::DEMAND_W'(-req.pitch_moment) : req.pitch_moment;
      absr = req.roll_moment[qrtm_pkg::DEMAND_W-1]
           ? qrtm_pkg::DEMAND_W'(-req.roll_moment) : req.roll_moment;
      prodp_in = absp * cfg.mass_gain;
      prodr_in = absr * cfg.mass_gain;
   end

   // scale, saturate and sign
   always_comb begin
      mp   = prodp_ff[qrtm_pkg::MPROD_W-1:17];
      mr   = prodr_ff[qrtm_pkg::MPROD_W-1:17];
      sp   = (mp > qrtm_pkg::MMAG_W'(qrtm_pkg::MASS_SAT)) ? qrtm_pkg::MASS_SAT
                                                           : mp[qrtm_pkg::MASS_W-2:0];
      sr   = (mr > qrtm_pkg::MMAG_W'(qrtm_pkg::MASS_SAT)) ? qrtm_pkg::MASS_SAT
                                                           : mr[qrtm_pkg::MASS_W-2:0];
      posp = $signed({1'b0, sp});
      posr = $signed({1'b0, sr});
      sat_in.valid = v1_ff;
      if (en_ff) begin
         sat_in.front = negp_ff ? -posp : posp;
         sat_in.right = negr_ff ? posr : -posr;
         sat_in.back  = negp_ff ? posp : -posp;
         sat_in.left  = negr_ff ? -posr : posr;
      end else begin
         sat_in.front = '0;
         sat_in.right = '0;
         sat_in.back  = '0;
         sat_in.left  = '0;
      end
   end

   always_ff @(posedge clock) begin
      en_ff    <= cfg.mass_mode;
      negp_ff  <= req.pitch_moment[qrtm_pkg::DEMAND_W-1];
      negr_ff  <= req.roll_moment[qrtm_pkg::DEMAND_W-1];
      prodp_ff <= prodp_in;
      prodr_ff <= prodr_in;
      chain_ff[0].front <= sat_in.front;
      chain_ff[0].right <= sat_in.right;
      chain_ff[0].back  <= sat_in.back;
      chain_ff[0].left  <= sat_in.left;
      for (int k = 1; k < C; k++) begin
         chain_ff[k].front <= chain_ff[k-1].front;
         chain_ff[k].right <= chain_ff[k-1].right;
         chain_ff[k].back  <= chain_ff[k-1].back;
         chain_ff[k].left  <= chain_ff[k-1].left;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         for (int k = 0; k < C; k++) begin
            chain_ff[k].valid <= 1'b0;
         end
      end else begin
         v1_ff <= in_valid;
         chain_ff[0].valid <= sat_in.valid;
         for (int k = 1; k < C; k++) begin
            chain_ff[k].valid <= chain_ff[k-1].valid;
         end
      end
   end

   assign mass_out = chain_ff[C-1];

endmodule

### src/quad_rotor_thrust_mixer.sv
// quad_rotor_thrust_mixer: top level, control registers, mixer, four speed lanes, mass path
// depends on qrtm_pkg, qrtm_mix, qrtm_lane, qrtm_mass
//
// usage
//  - a demand beat (thrust, roll, pitch, yaw) is taken on a clock edge with start high
//    and busy low; busy is high only during reset and the cycle after it
//  - a new beat may be taken on every cycle; throughput is one beat per clock
//  - the result beat (four signed rotor speeds, four mass setpoints) appears once its demand
//    beat has passed every stage below, on rsp_data for exactly one cycle with rsp_strobe high
//  - the square root is the longest part: 19 stages, one result bit per stage, after
//    three mixing stages and two multiply stages, and followed by one limit stage
//  - the receiver cannot hold results off, so nothing ever waits inside the block
//  - control registers are written through csr_we, csr_index, csr_wdata on an edge with csr_we high;
//    unknown indexes are dropped and data is cut to the register width
//  - write them only while no demand beat is in flight
//  - reset clears all in-flight beats and loads the default gains and limits
module quad_rotor_thrust_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  qrtm_pkg::req_type                    req_data,
   output logic                                 rsp_strobe,
   output qrtm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [qrtm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qrtm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                              busy_ff;
   logic                              accept;

   logic                              mass_mode_ff;
   logic [qrtm_pkg::GAIN_W-1:0]       rp_gain_ff;
   logic [qrtm_pkg::GAIN_W-1:0]       yaw_gain_ff;
   logic [qrtm_pkg::IMC_W-1:0]        inv_motor_ff;
   logic [qrtm_pkg::SQRT_BITS-1:0]    max_speed_ff;
   logic [qrtm_pkg::GAIN_W-1:0]       mass_gain_ff;
   qrtm_pkg::cfg_type                 cfg;

   qrtm_pkg::lane_in_type  [qrtm_pkg::LANES-1:0] lane_in;
   qrtm_pkg::lane_out_type [qrtm_pkg::LANES-1:0] lane_out;
   qrtm_pkg::mass_out_type                       mass_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_mode_ff <= 1'b0;
         rp_gain_ff   <= qrtm_pkg::RST_RP_GAIN;
         yaw_gain_ff  <= qrtm_pkg::RST_YAW_GAIN;
         inv_motor_ff <= qrtm_pkg::RST_INV_MOTOR;
         max_speed_ff <= qrtm_pkg::RST_MAX_SPEED;
         mass_gain_ff <= qrtm_pkg::RST_MASS_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            qrtm_pkg::CSR_MASS_MODE: begin
               mass_mode_ff <= csr_wdata[0];
            end
            qrtm_pkg::CSR_RP_GAIN: begin
               rp_gain_ff <= csr_wdata[qrtm_pkg::GAIN_W-1:0];
            end
            qrtm_pkg::CSR_YAW_GAIN: begin
               yaw_gain_ff <= csr_wdata[qrtm_pkg::GAIN_W-1:0];
            end
            qrtm_pkg::CSR_INV_MOTOR: begin
               inv_motor_ff <= csr_wdata[qrtm_pkg::IMC_W-1:0];
            end
            qrtm_pkg::CSR_MAX_SPEED: begin
               max_speed_ff <= csr_wdata[qrtm_pkg::SQRT_BITS-1:0];
            end
            qrtm_pkg::CSR_MASS_GAIN: begin
               mass_gain_ff <= csr_wdata[qrtm_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.mass_mode = mass_mode_ff;
      cfg.rp_gain   = rp_gain_ff;
      cfg.yaw_gain  = yaw_gain_ff;
      cfg.inv_motor = inv_motor_ff;
      cfg.max_speed = max_speed_ff;
      cfg.mass_gain = mass_gain_ff;
   end

   qrtm_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .req      (req_data),
      .cfg      (cfg),
      .lane_out (lane_in)
   );

   for (genvar i = 0; i < qrtm_pkg::LANES; i++) begin : g_lane
      qrtm_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lane_in[i]),
         .cfg      (cfg),
         .lane_out (lane_out[i])
      );
   end

   qrtm_mass u_mass (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .req      (req_data),
      .cfg      (cfg),
      .mass_out (mass_out)
   );

   assign rsp_strobe = lane_out[0].valid;

   always_comb begin
      rsp_data.speed_front = lane_out[0].speed;
      rsp_data.speed_right = lane_out[1].speed;
      rsp_data.speed_back  = lane_out[2].speed;
      rsp_data.speed_left  = lane_out[3].speed;
      rsp_data.mass_front  = mass_out.front;
      rsp_data.mass_right  = mass_out.right;
      rsp_data.mass_back   = mass_out.back;
      rsp_data.mass_left   = mass_out.left;
   end

   a_mass_aligned: assert property (@(posedge clock) disable iff (reset)
      mass_out.valid == lane_out[0].valid && lane_out[3].valid == lane_out[0].valid)
      else $error("mass path and speed lanes out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(qrtm_pkg::PIPE_DEPTH) rsp_strobe)
      else $error("demand beat produced no result beat");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, qrtm_pkg::PIPE_DEPTH))
      else $error("result beat without a demand beat");

endmodule
